### rtl/hcbd_pkg.sv
// ---------------------------------------------------------------------------
// hcbd_pkg: shared definitions for the chunked body decoder
// Parser phase codes, result kinds, character codes and the size line
// limit.
// ---------------------------------------------------------------------------
package hcbd_pkg;

   localparam int MAX_LINE_BYTES = 18;
   localparam int LINE_COUNT_W   = $clog2(MAX_LINE_BYTES + 1);
   localparam int SIZE_W         = 64;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [2:0] PH_SIZE = 3'd0;
   localparam logic [2:0] PH_DATA = 3'd1;
   localparam logic [2:0] PH_CR   = 3'd2;
   localparam logic [2:0] PH_LF   = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;
   localparam logic [2:0] PH_ERR  = 3'd5;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h41 + 8'd10);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

### rtl/http_chunked_body_decoder.sv
// ---------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked body decoder
// Parses size lines, passes chunk data on, flags body end and format errors.
// ---------------------------------------------------------------------------
// One byte is taken per cycle while req_stall is low; it passes the parser
// state update, a 64-bit decrement and compare on the remaining chunk count,
// and its result is registered in the output stage. A size line holds at
// most 16 hex digits and a CR before its LF, with no extensions and no
// trailers. Each data byte gives a payload result, the LF after the final
// zero-size chunk gives one body-complete result, and any format fault gives
// one error result; after either, bytes give nothing until req_body_start is
// raised with the first byte of a new body. Size line bytes and CR LF bytes
// give no result. A two-entry output stage lets input keep flowing while
// rsp_stall is high, and req_stall rises only once both entries hold results.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_body_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_out_kind
);

   localparam int LCW = hcbd_pkg::LINE_COUNT_W;
   localparam int SW  = hcbd_pkg::SIZE_W;

   logic [2:0]     phase_ff, phase_in, cur_phase;
   logic [SW-1:0]  chunk_ff, chunk_in, cur_chunk;
   logic [LCW-1:0] line_ff, line_in, cur_line, line_inc;
   logic [SW-1:0]  size_ff, size_in, cur_size;
   logic           last_ff, last_in, cur_last;
   logic           seen_cr_ff, seen_cr_in, cur_seen_cr;

   logic           emit;
   logic [1:0]     emit_kind;
   logic [7:0]     emit_byte;
   logic           fault;
   hcbd_pkg::hex_type hex;

   logic           out_valid_ff, skid_valid_ff;
   logic [7:0]     out_byte_ff, skid_byte_ff;
   logic [1:0]     out_kind_ff, skid_kind_ff;

   logic           accept, pop, res_valid;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;
   assign res_valid = accept && emit;

   // body start clears the parser before this byte is taken
   always_comb begin
      if (req_body_start) begin
         cur_phase   = hcbd_pkg::PH_SIZE;
         cur_chunk   = '0;
         cur_line    = '0;
         cur_size    = '0;
         cur_last    = 1'b0;
         cur_seen_cr = 1'b0;
      end else begin
         cur_phase   = phase_ff;
         cur_chunk   = chunk_ff;
         cur_line    = line_ff;
         cur_size    = size_ff;
         cur_last    = last_ff;
         cur_seen_cr = seen_cr_ff;
      end
   end

   assign hex      = hcbd_pkg::hex_decode(req_in_byte);
   assign line_inc = cur_line + LCW'(1);

   always_comb begin
      phase_in   = cur_phase;
      chunk_in   = cur_chunk;
      line_in    = cur_line;
      size_in    = cur_size;
      last_in    = cur_last;
      seen_cr_in = cur_seen_cr;
      emit       = 1'b0;
      emit_kind  = hcbd_pkg::KIND_DATA;
      emit_byte  = 8'd0;
      fault      = 1'b0;
      case (cur_phase)
         hcbd_pkg::PH_SIZE: begin
            if (req_in_byte == hcbd_pkg::CHAR_LF) begin
               if (!cur_seen_cr || cur_line < LCW'(2)) begin
                  fault = 1'b1;
               end else begin
                  last_in    = (cur_size == '0);
                  chunk_in   = cur_size;
                  line_in    = '0;
                  size_in    = '0;
                  seen_cr_in = 1'b0;
                  phase_in   = (cur_size == '0) ? hcbd_pkg::PH_CR : hcbd_pkg::PH_DATA;
               end
            end else if (line_inc >= LCW'(hcbd_pkg::MAX_LINE_BYTES)) begin
               fault = 1'b1;
            end else if (cur_seen_cr) begin
               fault = 1'b1;
            end else if (req_in_byte == hcbd_pkg::CHAR_CR) begin
               line_in    = line_inc;
               seen_cr_in = 1'b1;
            end else if (!hex.ok) begin
               fault = 1'b1;
            end else begin
               line_in = line_inc;
               size_in = {cur_size[SW-5:0], hex.value};
            end
         end
         hcbd_pkg::PH_DATA: begin
            chunk_in  = cur_chunk - SW'(1);
            if (cur_chunk == SW'(1)) begin
               phase_in = hcbd_pkg::PH_CR;
            end
            emit      = 1'b1;
            emit_kind = hcbd_pkg::KIND_DATA;
            emit_byte = req_in_byte;
         end
         hcbd_pkg::PH_CR: begin
            if (req_in_byte != hcbd_pkg::CHAR_CR) begin
               fault = 1'b1;
            end else begin
               phase_in = hcbd_pkg::PH_LF;
            end
         end
         hcbd_pkg::PH_LF: begin
            if (req_in_byte != hcbd_pkg::CHAR_LF) begin
               fault = 1'b1;
            end else if (cur_last) begin
               phase_in  = hcbd_pkg::PH_DONE;
               last_in   = 1'b0;
               emit      = 1'b1;
               emit_kind = hcbd_pkg::KIND_DONE;
            end else begin
               phase_in   = hcbd_pkg::PH_SIZE;
               line_in    = '0;
               size_in    = '0;
               seen_cr_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (fault) begin
         phase_in   = hcbd_pkg::PH_ERR;
         chunk_in   = '0;
         line_in    = '0;
         size_in    = '0;
         seen_cr_in = 1'b0;
         emit       = 1'b1;
         emit_kind  = hcbd_pkg::KIND_ERROR;
         emit_byte  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hcbd_pkg::PH_SIZE;
         chunk_ff   <= '0;
         line_ff    <= '0;
         size_ff    <= '0;
         last_ff    <= 1'b0;
         seen_cr_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         chunk_ff   <= chunk_in;
         line_ff    <= line_in;
         size_ff    <= size_in;
         last_ff    <= last_in;
         seen_cr_ff <= seen_cr_in;
      end
   end

   // output register with a skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || pop) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               out_byte_ff   <= skid_byte_ff;
               out_kind_ff   <= skid_kind_ff;
               skid_valid_ff <= res_valid;
               skid_byte_ff  <= emit_byte;
               skid_kind_ff  <= emit_kind;
            end else begin
               out_valid_ff <= res_valid;
               out_byte_ff  <= emit_byte;
               out_kind_ff  <= emit_kind;
            end
         end else if (res_valid) begin
            // hold the stalled result, park the new one
            skid_valid_ff <= 1'b1;
            skid_byte_ff  <= emit_byte;
            skid_kind_ff  <= emit_kind;
         end
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_kind = out_kind_ff;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while output register is empty");

   a_data_has_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hcbd_pkg::PH_DATA) |-> (chunk_ff != '0))
      else $error("data phase entered with no bytes remaining");

   a_end_clears_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hcbd_pkg::PH_DONE || phase_ff == hcbd_pkg::PH_ERR) |-> (chunk_ff == '0))
      else $error("chunk count left over after body end or error");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_kind_ff != 2'd3))
      else $error("undefined result kind presented");
`endif

endmodule

### tb/sv/http_chunked_body_decoder_tb.sv
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_tb: regression for the chunked body decoder
// Drives a directed table of bodies, format faults and overlong lines, then
// random well-formed, broken and noisy bodies. Results go against a typed
// result or a byte-serial parser model kept in step with accepted transfers.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 530;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 64;
   localparam int CALM_FROM    = 300;
   localparam int CALM_TO      = 420;
   localparam int N_ROWS       = 42;

   // how a directed row is checked: by the parser model or by a typed result
   typedef enum logic [2:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_DATA,
      CHECK_DONE,
      CHECK_ERROR
   } check_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
   } result_type;

   typedef struct {
      logic [7:0] code;
      logic       start;
      check_type  chk;
   } stim_type;

   typedef struct {
      logic [7:0] code;
      logic       start;
      int         reps;
      check_type  chk;
   } row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_body_start;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_out_kind;

   // parser model state
   logic [2:0]                        ph;
   logic [63:0]                       chunk_left;
   logic [hcbd_pkg::LINE_COUNT_W-1:0] line_bytes;
   logic [63:0]                       size_acc;
   logic                              final_chunk;
   logic                              got_cr;

   stim_type   stim_q [$];
   result_type decoded_q [$];
   int         n_accepted = 0;
   int         n_fail     = 0;
   int         n_cycles   = 0;

   // start bit applies to the first repetition of a row only
   row_type dir_rows [N_ROWS] = '{
      // two payload bytes at the extremes, then the zero-size chunk
      '{"2",               1'b1, 1,  CHECK_NONE},
      '{hcbd_pkg::CHAR_CR, 1'b0, 1,  CHECK_NONE},
      '{hcbd_pkg::CHAR_LF, 1'b0, 1,  CHECK_NONE},
      '{8'h00,             1'b0, 1,  CHECK_DATA},
      '{8'hFF,             1'b0, 1,  CHECK_DATA},
      '{hcbd_pkg::CHAR_CR, 1'b0, 1,  CHECK_NONE},
      '{hcbd_pkg::CHAR_LF, 1'b0, 1,  CHECK_NONE},
      '{"0",               1'b0, 1,  CHECK_NONE},
      '{hcbd_pkg::CHAR_CR, 1'b0, 1,  CHECK_NONE},
      '{hcbd_pkg::CHAR_LF, 1'b0, 1,  CHECK_NONE},
      '{hcbd_pkg::CHAR_CR, 1'b0, 1,  CHECK_NONE},
      '{hcbd_pkg::CHAR_LF, 1'b0, 1,  CHECK_DONE},
      '{"Z",               1'b0, 1,  CHECK_NONE},
      // LF with neither digits nor CR
      '{hcbd_pkg::CHAR_LF, 1'b1, 1,  CHECK_ERROR},
      // CR LF with no digits
      '{hcbd_pkg::CHAR_CR, 1'b1, 1,  CHECK_NONE},
      '{hcbd_pkg::CHAR_LF, 1'b0, 1,  CHECK_ERROR},
      // digit then LF without CR; the byte after the fault is dropped
      '{"a",               1'b1, 1,  CHECK_NONE},
      '{hcbd_pkg::CHAR_LF, 1'b0, 1,  CHECK_ERROR},
      '{8'h80,             1'b0, 1,  CHECK_NONE},
      '{"G",               1'b1, 1,  CHECK_ERROR},
      // anything but LF after the CR
      '{"B",               1'b1, 1,  CHECK_NONE},
      '{hcbd_pkg::CHAR_CR, 1'b0, 1,  CHECK_NONE},
      '{"x",               1'b0, 1,  CHECK_ERROR},
      // chunk data not followed by CR
      '{"1",               1'b1, 1,  CHECK_MODEL},
      '{hcbd_pkg::CHAR_CR, 1'b0, 1,  CHECK_MODEL},
      '{hcbd_pkg::CHAR_LF, 1'b0, 1,  CHECK_MODEL},
      '{"q",               1'b0, 1,  CHECK_MODEL},
      '{hcbd_pkg::CHAR_LF, 1'b0, 1,  CHECK_ERROR},
      // chunk CR not followed by LF
      '{"1",               1'b1, 1,  CHECK_MODEL},
      '{hcbd_pkg::CHAR_CR, 1'b0, 1,  CHECK_MODEL},
      '{hcbd_pkg::CHAR_LF, 1'b0, 1,  CHECK_MODEL},
      '{"q",               1'b0, 1,  CHECK_MODEL},
      '{hcbd_pkg::CHAR_CR, 1'b0, 1,  CHECK_MODEL},
      '{"x",               1'b0, 1,  CHECK_ERROR},
      // size line reaching the byte limit without an LF
      '{"F",               1'b1, 1,  CHECK_NONE},
      '{"c",               1'b0, 16, CHECK_MODEL},
      '{"7",               1'b0, 1,  CHECK_ERROR},
      // largest size: 16 digits, cut short by the next body
      '{"F",               1'b1, 1,  CHECK_MODEL},
      '{"f",               1'b0, 15, CHECK_MODEL},
      '{hcbd_pkg::CHAR_CR, 1'b0, 1,  CHECK_MODEL},
      '{hcbd_pkg::CHAR_LF, 1'b0, 1,  CHECK_MODEL},
      '{"E",               1'b0, 3,  CHECK_MODEL}
   };

   http_chunked_body_decoder i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_body_start (req_body_start),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_kind   (rsp_out_kind)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic clear_parser();
      ph          = hcbd_pkg::PH_SIZE;
      chunk_left  = '0;
      line_bytes  = '0;
      size_acc    = '0;
      final_chunk = 1'b0;
      got_cr      = 1'b0;
   endtask

   // advance the parser model by one byte; hit is set when a result is due
   task automatic parse_byte(input logic [7:0] b, input logic start,
                             output logic hit, output result_type r);
      logic       bad;
      logic       is_hex;
      logic [3:0] nib;
      bad = 1'b0;
      hit = 1'b0;
      r   = '{out_byte: 8'h00, out_kind: hcbd_pkg::KIND_DATA};
      if (start) begin
         clear_parser();
      end
      is_hex = 1'b1;
      nib    = b[3:0];
      if (b >= "0" && b <= "9") begin
         nib = b[3:0];
      end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
         nib = b[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end
      case (ph)
         hcbd_pkg::PH_SIZE: begin
            if (b == hcbd_pkg::CHAR_LF) begin
               if (!got_cr || line_bytes < 2) begin
                  bad = 1'b1;
               end else begin
                  final_chunk = (size_acc == 64'd0);
                  chunk_left  = size_acc;
                  line_bytes  = '0;
                  size_acc    = '0;
                  got_cr      = 1'b0;
                  ph          = final_chunk ? hcbd_pkg::PH_CR : hcbd_pkg::PH_DATA;
               end
            end else begin
               line_bytes = line_bytes + 1'b1;
               if (line_bytes >= hcbd_pkg::MAX_LINE_BYTES || got_cr) begin
                  bad = 1'b1;
               end else if (b == hcbd_pkg::CHAR_CR) begin
                  got_cr = 1'b1;
               end else if (!is_hex) begin
                  bad = 1'b1;
               end else begin
                  size_acc = {size_acc[59:0], nib};
               end
            end
         end
         hcbd_pkg::PH_DATA: begin
            chunk_left = chunk_left - 64'd1;
            if (chunk_left == 64'd0) begin
               ph = hcbd_pkg::PH_CR;
            end
            hit = 1'b1;
            r   = '{out_byte: b, out_kind: hcbd_pkg::KIND_DATA};
         end
         hcbd_pkg::PH_CR: begin
            if (b != hcbd_pkg::CHAR_CR) begin
               bad = 1'b1;
            end else begin
               ph = hcbd_pkg::PH_LF;
            end
         end
         hcbd_pkg::PH_LF: begin
            if (b != hcbd_pkg::CHAR_LF) begin
               bad = 1'b1;
            end else if (final_chunk) begin
               ph          = hcbd_pkg::PH_DONE;
               final_chunk = 1'b0;
               hit         = 1'b1;
               r           = '{out_byte: 8'h00, out_kind: hcbd_pkg::KIND_DONE};
            end else begin
               ph         = hcbd_pkg::PH_SIZE;
               line_bytes = '0;
               size_acc   = '0;
               got_cr     = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (bad) begin
         ph         = hcbd_pkg::PH_ERR;
         chunk_left = '0;
         line_bytes = '0;
         size_acc   = '0;
         got_cr     = 1'b0;
         hit        = 1'b1;
         r          = '{out_byte: 8'h00, out_kind: hcbd_pkg::KIND_ERROR};
      end
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + 8'(nib);
      end
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
   endfunction

   // mostly well-formed bodies with random content, some broken, some noise
   task automatic build_random_stream(input int n_items);
      logic [7:0]  body [$];
      logic [63:0] size;
      int          n_chunks;
      int          n_dig;
      int          n_pad;
      logic        giant;
      while (stim_q.size() < n_items) begin
         if ($urandom_range(11) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               stim_q.push_back('{8'($urandom), ($urandom_range(3) == 0), CHECK_MODEL});
            end
            continue;
         end
         body.delete();
         giant    = ($urandom_range(24) == 0);
         n_chunks = giant ? 0 : $urandom_range(0, 3);
         for (int c = 0; c <= n_chunks; c++) begin
            if (giant) begin
               size = {$urandom, $urandom} | (64'h1 << 63);
            end else if (c == n_chunks) begin
               size = 64'd0;
            end else if ($urandom_range(7) == 0) begin
               size = 64'($urandom_range(17, 40));
            end else begin
               size = 64'($urandom_range(1, 8));
            end
            n_dig = 1;
            while (n_dig < 16 && (size >> (4 * n_dig)) != 64'd0) begin
               n_dig++;
            end
            // leading zeros now and then push the line past its limit
            n_pad = ($urandom_range(7) == 0) ? $urandom_range(0, 17 - n_dig)
                                             : $urandom_range(0, 2);
            repeat (n_pad) begin
               body.push_back("0");
            end
            for (int d = n_dig - 1; d >= 0; d--) begin
               body.push_back(hex_char(4'(size >> (4 * d))));
            end
            body.push_back(hcbd_pkg::CHAR_CR);
            body.push_back(hcbd_pkg::CHAR_LF);
            if (giant) begin
               repeat ($urandom_range(1, 20)) begin
                  body.push_back(8'($urandom));
               end
            end else begin
               repeat (int'(size)) begin
                  body.push_back(8'($urandom));
               end
               body.push_back(hcbd_pkg::CHAR_CR);
               body.push_back(hcbd_pkg::CHAR_LF);
            end
         end
         if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
               0:       body[$urandom_range(body.size() - 1)] = hcbd_pkg::CHAR_CR;
               1:       body[$urandom_range(body.size() - 1)] = hcbd_pkg::CHAR_LF;
               2:       body[$urandom_range(body.size() - 1)] = hex_char(4'($urandom));
               default: body[$urandom_range(body.size() - 1)] = 8'($urandom);
            endcase
         end
         if ($urandom_range(9) == 0) begin
            body = body[0:$urandom_range(body.size() - 1)];
         end
         foreach (body[i]) begin
            stim_q.push_back('{body[i], (i == 0), CHECK_MODEL});
         end
      end
   endtask

   // sample both channels; results are checked before new predictions land
   always @(posedge clock) begin : monitor
      logic       hit;
      result_type r;
      result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: result with none due: kind %0d byte %0d",
                        $realtime, rsp_out_kind, rsp_out_byte);
               n_fail++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_out_kind !== want.out_kind) begin
                  $display("%0t: out_kind mismatch: expected %0d, actual %0d",
                           $realtime, want.out_kind, rsp_out_kind);
                  n_fail++;
               end
               if (rsp_out_byte !== want.out_byte) begin
                  $display("%0t: out_byte mismatch: expected 0x%02h, actual 0x%02h",
                           $realtime, want.out_byte, rsp_out_byte);
                  n_fail++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            parse_byte(req_in_byte, req_body_start, hit, r);
            case (stim_q[n_accepted].chk)
               CHECK_MODEL: begin
                  if (hit) begin
                     decoded_q.push_back(r);
                  end
               end
               CHECK_DATA: begin
                  decoded_q.push_back('{out_byte: req_in_byte,
                                        out_kind: hcbd_pkg::KIND_DATA});
               end
               CHECK_DONE: begin
                  decoded_q.push_back('{out_byte: 8'h00, out_kind: hcbd_pkg::KIND_DONE});
               end
               CHECK_ERROR: begin
                  decoded_q.push_back('{out_byte: 8'h00, out_kind: hcbd_pkg::KIND_ERROR});
               end
               default: begin
               end
            endcase
            n_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("http_chunked_body_decoder regression: fail");
         $finish;
      end
   end

   // result side: random stall, one long hold-off, a calm stretch
   initial begin : receiver
      logic held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!held && n_accepted >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (n_accepted >= CALM_FROM && n_accepted < CALM_TO) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 23);
         end
      end
   end

   initial begin : sender
      int n_directed;
      int drain_at;
      int gap;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_in_byte    = 8'h00;
      req_body_start = 1'b0;
      clear_parser();
      foreach (dir_rows[i]) begin
         for (int r = 0; r < dir_rows[i].reps; r++) begin
            stim_q.push_back('{dir_rows[i].code, dir_rows[i].start && r == 0,
                               dir_rows[i].chk});
         end
      end
      n_directed = stim_q.size();
      drain_at   = n_directed + 250;
      build_random_stream(n_directed + RANDOM_ITEMS);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int k = 0; k < stim_q.size(); k++) begin
         gap = 0;
         if (k < CALM_FROM || k >= CALM_TO) begin
            while ($urandom_range(99) < 23) begin
               gap++;
            end
         end
         if (gap > 0 || k == drain_at) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
            if (k == drain_at) begin
               // hold the input until every due result has drained
               @(negedge clock);
               while (decoded_q.size() != 0) begin
                  @(negedge clock);
               end
            end
         end
         req_valid      <= 1'b1;
         req_in_byte    <= stim_q[k].code;
         req_body_start <= stim_q[k].start;
         @(negedge clock);
         while (n_accepted <= k) begin
            @(negedge clock);
         end
      end
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (10) @(negedge clock);
      if (n_fail == 0 && decoded_q.size() == 0) begin
         $display("http_chunked_body_decoder regression: pass");
      end else begin
         $display("http_chunked_body_decoder regression: fail");
      end
      $finish;
   end

endmodule
